@@ rtl/kind_ancestry_table_defines.svh @@
// Assertion macros used by the kind ancestry table RTL.
`ifndef KIND_ANCESTRY_TABLE_DEFINES_SVH
`define KIND_ANCESTRY_TABLE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define KAT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define KAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/kat_pkg.sv @@
// Types and constants for the kind ancestry table.
package kat_pkg;

   localparam int MAX_KINDS = 64;
   localparam int ID_W      = 6;
   localparam int ID_SPACE  = 1 << ID_W;
   localparam int CAPACITY  = (MAX_KINDS < ID_SPACE) ? MAX_KINDS : ID_SPACE;
   localparam int CNT_W     = $clog2(ID_SPACE + 1);

   localparam logic [CNT_W-1:0] CAPACITY_C = CNT_W'(CAPACITY);
   localparam logic [ID_W-1:0]  WALK_LAST  = ID_W'(ID_SPACE - 1);

   typedef enum logic [1:0] {
      OP_ADD_ROOT    = 2'd0,
      OP_ADD_DERIVED = 2'd1,
      OP_IS_KIND_OF  = 2'd2,
      OP_LIST        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNALLOC = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_EMIT
   } state_type;

endpackage

@@ rtl/kind_ancestry_table.sv @@
// Kind ancestry table: parent-pointer store with ancestor walk and listing.
// Adds, rejected queries and is-kind-of on the base itself go to the emit state, which registers the result.
// Is-kind-of walks one parent RAM read per cycle until a root, the base or the step budget.
// List ancestors gives one result word per cycle while the output is free, after the first read, up to 64 words.
// One item is in flight at a time; the parent RAM read port sets the walk rate.
// Reset clears the fill count and control; table contents stay unknown until written.
`include "kind_ancestry_table_defines.svh"

module kind_ancestry_table (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_opcode,
   input  logic [kat_pkg::ID_W-1:0] req_parent_id,
   input  logic [kat_pkg::ID_W-1:0] req_base_id,
   input  logic [kat_pkg::ID_W-1:0] req_kind_id,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [kat_pkg::ID_W-1:0] rsp_new_id,
   output logic                    rsp_is_derived,
   output logic [kat_pkg::ID_W-1:0] rsp_ancestor_id,
   output logic                    rsp_last,
   output logic [1:0]              rsp_status
);

   localparam int IW = kat_pkg::ID_W;
   localparam int CW = kat_pkg::CNT_W;

   kat_pkg::state_type state_ff, state_in;
   kat_pkg::op_type    op_ff, op_in, req_op;
   logic [CW-1:0]      used_ff, used_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [IW-1:0]      base_ff, base_in;
   logic [IW-1:0]      cnt_ff, cnt_in;

   logic [IW-1:0]        pend_new_ff, pend_new_in;
   logic                 pend_der_ff, pend_der_in;
   kat_pkg::status_type  pend_status_ff, pend_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_new_ff, rsp_new_in;
   logic                 rsp_der_ff, rsp_der_in;
   logic [IW-1:0]        rsp_anc_ff, rsp_anc_in;
   logic                 rsp_last_ff, rsp_last_in;
   kat_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic          ram_wr_en, ram_rd_en;
   logic [IW-1:0] ram_wr_addr, ram_wr_data, ram_rd_addr, ram_rd_data;

   logic out_free, load_out, chain_end;

   assign req_op   = kat_pkg::op_type'(req_opcode);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign chain_end = (ram_rd_data == cur_ff) || (cnt_ff == kat_pkg::WALK_LAST);

   // Parent table
   kat_ram #(
      .WIDTH (IW),
      .DEPTH (kat_pkg::ID_SPACE)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kat_pkg::S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and result payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cur_ff         <= cur_in;
      base_ff        <= base_in;
      cnt_ff         <= cnt_in;
      pend_new_ff    <= pend_new_in;
      pend_der_ff    <= pend_der_in;
      pend_status_ff <= pend_status_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_der_ff     <= rsp_der_in;
      rsp_anc_ff     <= rsp_anc_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Sequence each word: decide, walk the parent links, emit
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      used_in        = used_ff;
      cur_in         = cur_ff;
      base_in        = base_ff;
      cnt_in         = cnt_ff;
      pend_new_in    = pend_new_ff;
      pend_der_in    = pend_der_ff;
      pend_status_in = pend_status_ff;
      req_ready      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = used_ff[IW-1:0];
      ram_wr_data    = req_parent_id;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = req_kind_id;
      load_out       = 1'b0;
      rsp_new_in     = rsp_new_ff;
      rsp_der_in     = rsp_der_ff;
      rsp_anc_in     = rsp_anc_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         kat_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in          = req_op;
               base_in        = req_base_id;
               cur_in         = req_kind_id;
               cnt_in         = '0;
               pend_new_in    = '0;
               pend_der_in    = 1'b0;
               pend_status_in = kat_pkg::ST_OK;
               state_in       = kat_pkg::S_EMIT;
               unique case (req_op) inside
                  kat_pkg::OP_ADD_ROOT, kat_pkg::OP_ADD_DERIVED: begin
                     if (used_ff >= kat_pkg::CAPACITY_C) begin
                        pend_status_in = kat_pkg::ST_FULL;
                     end else if (req_op == kat_pkg::OP_ADD_DERIVED &&
                                  {1'b0, req_parent_id} >= used_ff) begin
                        pend_status_in = kat_pkg::ST_UNALLOC;
                     end else begin
                        // Allocate the next identifier; a root points at itself
                        ram_wr_en = 1'b1;
                        if (req_op == kat_pkg::OP_ADD_ROOT) begin
                           ram_wr_data = used_ff[IW-1:0];
                        end
                        used_in     = used_ff + CW'(1);
                        pend_new_in = used_ff[IW-1:0];
                     end
                  end
                  kat_pkg::OP_IS_KIND_OF, kat_pkg::OP_LIST: begin
                     if ({1'b0, req_kind_id} >= used_ff ||
                         (req_op == kat_pkg::OP_IS_KIND_OF &&
                          {1'b0, req_base_id} >= used_ff)) begin
                        pend_status_in = kat_pkg::ST_UNALLOC;
                     end else if (req_op == kat_pkg::OP_IS_KIND_OF &&
                                  req_kind_id == req_base_id) begin
                        pend_der_in = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = kat_pkg::S_WALK;
                     end
                  end
                  default: begin
                     state_in = kat_pkg::S_EMIT;
                  end
               endcase
            end
         end

         kat_pkg::S_WALK: begin
            ram_rd_addr = ram_rd_data;
            if (op_ff == kat_pkg::OP_LIST) begin
               // Emit one chain member per free output slot; hold the read data otherwise
               if (out_free) begin
                  load_out      = 1'b1;
                  rsp_new_in    = '0;
                  rsp_der_in    = 1'b0;
                  rsp_anc_in    = cur_ff;
                  rsp_last_in   = chain_end;
                  rsp_status_in = kat_pkg::ST_OK;
                  if (chain_end) begin
                     state_in = kat_pkg::S_IDLE;
                  end else begin
                     cur_in    = ram_rd_data;
                     cnt_in    = cnt_ff + IW'(1);
                     ram_rd_en = 1'b1;
                  end
               end
            end else begin
               // Stop at a root, at the base, or when the step budget runs out
               if (ram_rd_data == cur_ff) begin
                  state_in = kat_pkg::S_EMIT;
               end else if (ram_rd_data == base_ff) begin
                  pend_der_in = 1'b1;
                  state_in    = kat_pkg::S_EMIT;
               end else if (cnt_ff == kat_pkg::WALK_LAST) begin
                  state_in = kat_pkg::S_EMIT;
               end else begin
                  cur_in    = ram_rd_data;
                  cnt_in    = cnt_ff + IW'(1);
                  ram_rd_en = 1'b1;
               end
            end
         end

         kat_pkg::S_EMIT: begin
            if (out_free) begin
               load_out      = 1'b1;
               rsp_new_in    = pend_new_ff;
               rsp_der_in    = pend_der_ff;
               rsp_anc_in    = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = pend_status_ff;
               state_in      = kat_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = kat_pkg::S_IDLE;
         end
      endcase

      // Advance the output register
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_id      = rsp_new_ff;
   assign rsp_is_derived  = rsp_der_ff;
   assign rsp_ancestor_id = rsp_anc_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

   // Checks on the sequencer and table state
   `KAT_ASSERT_SAME(a_used_in_range, 1'b1, used_ff <= kat_pkg::CAPACITY_C, "fill count over capacity")
   `KAT_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != kat_pkg::S_IDLE, "accepted word did not start")
   `KAT_ASSERT_NEXT(a_chain_continues, rsp_valid && !rsp_last, rsp_valid, "gap inside an ancestor list")
   `KAT_ASSERT_SAME(a_walk_allocated, state_ff == kat_pkg::S_WALK, {1'b0, cur_ff} < used_ff, "walk reached an unallocated entry")

endmodule

@@ rtl/kat_ram.sv @@
// Generic single write, single read RAM with registered read data.
module kat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/tb_kind_ancestry_table.sv @@
// Self-checking testbench for the kind ancestry table: directed and random table operations.
module tb_kind_ancestry_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW           = kat_pkg::ID_W;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [IW-1:0]       new_id;
      logic                is_derived;
      logic [IW-1:0]       ancestor_id;
      logic                is_last;
      kat_pkg::status_type status;
   } kat_word_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [1:0]    req_opcode;
   logic [IW-1:0] req_parent_id;
   logic [IW-1:0] req_base_id;
   logic [IW-1:0] req_kind_id;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [IW-1:0] rsp_new_id;
   logic          rsp_is_derived;
   logic [IW-1:0] rsp_ancestor_id;
   logic          rsp_last;
   logic [1:0]    rsp_status;

   // Shadow copy of the table as the block should hold it
   logic [IW-1:0] kind_parent [kat_pkg::ID_SPACE];
   int            kind_depth [kat_pkg::ID_SPACE];
   int            kinds_alloc  = 0;
   logic [IW-1:0] deepest_kind = '0;

   kat_word_type pending_words [$];

   bit idle_on       = 1'b1;
   int hold_request  = 0;
   int error_count   = 0;
   int words_checked = 0;
   int longest_chain = 0;
   int cycle_count   = 0;
   int op_count [4]  = '{0, 0, 0, 0};

   kind_ancestry_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_parent_id   (req_parent_id),
      .req_base_id     (req_base_id),
      .req_kind_id     (req_kind_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_id      (rsp_new_id),
      .rsp_is_derived  (rsp_is_derived),
      .rsp_ancestor_id (rsp_ancestor_id),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Count a mismatch and print it on one line
   task automatic report_mismatch(string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic kat_word_type make_word(logic [IW-1:0] nid, logic der,
                                              logic [IW-1:0] anc, logic lst,
                                              kat_pkg::status_type st);
      kat_word_type w;
      w.new_id      = nid;
      w.is_derived  = der;
      w.ancestor_id = anc;
      w.is_last     = lst;
      w.status      = st;
      return w;
   endfunction

   // Append one expected word behind those already waiting
   function automatic void queue_word(kat_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Apply one accepted operation to the shadow table and queue its result words
   function automatic void predict_table_op(kat_pkg::op_type op, logic [IW-1:0] par,
                                            logic [IW-1:0] base,
                                            logic [IW-1:0] kind);
      logic [IW-1:0] cur;
      logic [IW-1:0] up;
      logic [IW-1:0] new_kind;
      logic          hit;
      logic          at_root;
      logic          done;
      int            steps;
      int            n;
      if (op == kat_pkg::OP_ADD_ROOT || op == kat_pkg::OP_ADD_DERIVED) begin
         if (kinds_alloc >= kat_pkg::CAPACITY) begin
            queue_word(make_word('0, 1'b0, '0, 1'b1, kat_pkg::ST_FULL));
         end else if (op == kat_pkg::OP_ADD_DERIVED && par >= kinds_alloc) begin
            queue_word(make_word('0, 1'b0, '0, 1'b1, kat_pkg::ST_UNALLOC));
         end else begin
            new_kind = IW'(kinds_alloc);
            kind_parent[new_kind] = (op == kat_pkg::OP_ADD_ROOT) ? new_kind : par;
            kind_depth[new_kind]  = (op == kat_pkg::OP_ADD_ROOT) ? 1 : kind_depth[par] + 1;
            if (kind_depth[new_kind] > kind_depth[deepest_kind] || kinds_alloc == 0)
               deepest_kind = new_kind;
            queue_word(make_word(new_kind, 1'b0, '0, 1'b1, kat_pkg::ST_OK));
            kinds_alloc++;
         end
      end else if (kind >= kinds_alloc ||
                   (op == kat_pkg::OP_IS_KIND_OF && base >= kinds_alloc)) begin
         queue_word(make_word('0, 1'b0, '0, 1'b1, kat_pkg::ST_UNALLOC));
      end else if (op == kat_pkg::OP_IS_KIND_OF) begin
         // Walk parent links until the base turns up or a root is reached
         cur     = kind;
         hit     = (cur == base);
         at_root = 1'b0;
         steps   = 0;
         while (!hit && !at_root && steps < kat_pkg::ID_SPACE) begin
            up = kind_parent[cur];
            if (up == cur) begin
               at_root = 1'b1;
            end else begin
               if (up == base) hit = 1'b1;
               cur = up;
               steps++;
            end
         end
         queue_word(make_word('0, hit, '0, 1'b1, kat_pkg::ST_OK));
      end else begin
         // One word per chain member, kind first, root marked last
         cur  = kind;
         n    = 0;
         done = 1'b0;
         while (!done) begin
            up   = kind_parent[cur];
            done = (up == cur) || (n + 1 >= kat_pkg::ID_SPACE);
            queue_word(make_word('0, 1'b0, cur, done, kat_pkg::ST_OK));
            n++;
            cur = up;
         end
         if (n > longest_chain) longest_chain = n;
      end
   endfunction

   function automatic logic [IW-1:0] rand_id();
      return IW'($urandom_range(0, kat_pkg::ID_SPACE - 1));
   endfunction

   function automatic logic [IW-1:0] pick_known_id();
      if (kinds_alloc == 0) return rand_id();
      return IW'($urandom_range(0, kinds_alloc - 1));
   endfunction

   // Climb a few levels from an allocated kind to get a likely hit
   function automatic logic [IW-1:0] pick_ancestor_of(logic [IW-1:0] kind);
      logic [IW-1:0] cur;
      int            steps;
      cur = kind;
      if (kind >= kinds_alloc) return kind;
      steps = $urandom_range(0, 8);
      repeat (steps) cur = kind_parent[cur];
      return cur;
   endfunction

   // Offer one word, hold it until accepted, then predict its results
   task automatic send_word(kat_pkg::op_type op, logic [IW-1:0] par, logic [IW-1:0] base,
                            logic [IW-1:0] kind);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_parent_id <= par;
      req_base_id   <= base;
      req_kind_id   <= kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table_op(op, par, base, kind);
      op_count[op]++;
   endtask

   task automatic send_random_query();
      logic [IW-1:0] kind;
      logic [IW-1:0] base;
      kind = ($urandom_range(0, 1) == 0) ? deepest_kind : pick_known_id();
      if ($urandom_range(0, 1) == 0) begin
         base = ($urandom_range(0, 2) == 0) ? pick_known_id() : pick_ancestor_of(kind);
         send_word(kat_pkg::OP_IS_KIND_OF, rand_id(), base, kind);
      end else begin
         send_word(kat_pkg::OP_LIST, rand_id(), rand_id(), kind);
      end
   endtask

   task automatic send_noise();
      send_word(kat_pkg::op_type'($urandom_range(0, 3)), rand_id(), rand_id(), rand_id());
   endtask

   // Queries and a derived add against an empty table
   task automatic test_empty_table();
      send_word(kat_pkg::OP_IS_KIND_OF, 6'd63, '0, '0);
      send_word(kat_pkg::OP_LIST, 6'd63, 6'd63, '0);
      send_word(kat_pkg::OP_ADD_DERIVED, '0, 6'd63, 6'd63);
      send_word(kat_pkg::OP_LIST, '0, '0, 6'd63);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd63, 6'd63);
   endtask

   // Two roots, a short chain and every query outcome on it
   task automatic test_first_kinds();
      send_word(kat_pkg::OP_ADD_ROOT, 6'd63, 6'd63, 6'd63);
      send_word(kat_pkg::OP_ADD_DERIVED, 6'd1, '0, '0);
      send_word(kat_pkg::OP_ADD_DERIVED, 6'd0, '0, '0);
      send_word(kat_pkg::OP_ADD_DERIVED, 6'd1, '0, '0);
      send_word(kat_pkg::OP_ADD_ROOT, '0, '0, '0);
      send_word(kat_pkg::OP_ADD_DERIVED, 6'd63, '0, '0);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd0, 6'd2);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd2, 6'd0);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd2, 6'd2);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd0, 6'd3);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd3, 6'd2);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd63, 6'd2);
      send_word(kat_pkg::OP_IS_KIND_OF, '0, 6'd0, 6'd63);
      send_word(kat_pkg::OP_LIST, '0, '0, 6'd2);
      send_word(kat_pkg::OP_LIST, '0, '0, 6'd3);
      send_word(kat_pkg::OP_LIST, '0, '0, 6'd0);
   endtask

   // Grow mostly deep chains until the table is full, querying as it grows
   task automatic test_grow_table();
      int            r;
      logic [IW-1:0] par;
      while (kinds_alloc < kat_pkg::CAPACITY) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            if ($urandom_range(0, 99) < 12) begin
               send_word(kat_pkg::OP_ADD_ROOT, rand_id(), rand_id(), rand_id());
            end else begin
               r   = $urandom_range(0, 99);
               par = (r < 70) ? deepest_kind : (r < 92) ? pick_known_id() : rand_id();
               send_word(kat_pkg::OP_ADD_DERIVED, par, rand_id(), rand_id());
            end
         end else if (r < 92) begin
            send_random_query();
         end else begin
            send_noise();
         end
      end
   endtask

   // Adds must now report a full table; queries and noise run against the full table
   task automatic test_full_table();
      int r;
      repeat (90) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            send_word($urandom_range(0, 1) ? kat_pkg::OP_ADD_ROOT : kat_pkg::OP_ADD_DERIVED,
                      rand_id(), rand_id(), rand_id());
         else if (r < 90)
            send_random_query();
         else
            send_noise();
      end
   endtask

   // Hold the result side off while long listings keep coming
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (8) send_word(kat_pkg::OP_LIST, rand_id(), rand_id(), deepest_kind);
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_final_no_idle();
      idle_on = 1'b0;
      repeat (30) begin
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_random_query();
      end
   endtask

   // Result side: random stall bursts, plus the long hold when requested
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every accepted result word with the oldest expectation
   initial begin
      kat_word_type want;
      kat_word_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.new_id      = rsp_new_id;
            got.is_derived  = rsp_is_derived;
            got.ancestor_id = rsp_ancestor_id;
            got.is_last     = rsp_last;
            got.status      = kat_pkg::status_type'(rsp_status);
            if (pending_words.size() == 0) begin
               report_mismatch($sformatf("word with nothing expected, ancestor %0d status %0d",
                                         got.ancestor_id, got.status));
            end else begin
               want = pending_words.pop_front();
               if (got.new_id !== want.new_id)
                  report_mismatch($sformatf("word %0d new_id %0d, expected %0d",
                                            words_checked, got.new_id, want.new_id));
               if (got.is_derived !== want.is_derived)
                  report_mismatch($sformatf("word %0d is_derived %0d, expected %0d",
                                            words_checked, got.is_derived, want.is_derived));
               if (got.ancestor_id !== want.ancestor_id)
                  report_mismatch($sformatf("word %0d ancestor_id %0d, expected %0d",
                                            words_checked, got.ancestor_id, want.ancestor_id));
               if (got.is_last !== want.is_last)
                  report_mismatch($sformatf("word %0d last %0d, expected %0d",
                                            words_checked, got.is_last, want.is_last));
               if (got.status !== want.status)
                  report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                            words_checked, got.status, want.status));
               words_checked++;
            end
         end
      end
   end

   // Drop the run if it overruns the cycle budget
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_words.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= kat_pkg::OP_ADD_ROOT;
      req_parent_id <= '0;
      req_base_id   <= '0;
      req_kind_id   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_first_kinds();
      test_grow_table();
      test_full_table();
      test_backpressure();
      test_final_no_idle();
      req_valid <= 1'b0;

      // Drain outstanding words, then allow for anything unexpected to surface
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d adds root, %0d adds derived, %0d kind-of checks, %0d listings",
               op_count[kat_pkg::OP_ADD_ROOT], op_count[kat_pkg::OP_ADD_DERIVED],
               op_count[kat_pkg::OP_IS_KIND_OF], op_count[kat_pkg::OP_LIST]);
      $display("checked %0d result words, longest chain %0d, %0d kinds, %0d mismatches",
               words_checked, longest_chain, kinds_alloc, error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ kind_ancestry_table.f @@
+incdir+rtl
rtl/kat_pkg.sv
rtl/kat_ram.sv
rtl/kind_ancestry_table.sv
dv/tb_kind_ancestry_table.sv
